@@ hdl/hold_and_modify_pixel_decoder_assert.svh @@
// Assertion macros for the hold-and-modify decoder checker.
`ifndef HOLD_AND_MODIFY_PIXEL_DECODER_ASSERT_SVH
`define HOLD_AND_MODIFY_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HAMD_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("hamd check failed");

// next-cycle implication, disabled in reset
`define HAMD_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("hamd check failed");

`endif

@@ hdl/hamd_pkg.sv @@
package hamd_pkg;

    localparam int PALETTE_DEPTH = 64;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int COLOR_W       = 32;
    localparam int CODE_W        = 6;
    localparam int NIB_W         = 4;
    localparam int SHIFT_W       = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CTRL_LOAD  = 2'd0,
        CTRL_BLUE  = 2'd1,
        CTRL_RED   = 2'd2,
        CTRL_GREEN = 2'd3
    } t_ctrl;

    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_KEEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_KEEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_KEEP  = 3'd5;

    localparam logic [SHIFT_W-1:0] RST_BLUE_SHIFT  = 5'd4;
    localparam logic [COLOR_W-1:0] RST_BLUE_KEEP   = 32'hFFFF_FF0F;
    localparam logic [SHIFT_W-1:0] RST_RED_SHIFT   = 5'd20;
    localparam logic [COLOR_W-1:0] RST_RED_KEEP    = 32'hFF0F_FFFF;
    localparam logic [SHIFT_W-1:0] RST_GREEN_SHIFT = 5'd12;
    localparam logic [COLOR_W-1:0] RST_GREEN_KEEP  = 32'hFFFF_0FFF;

    typedef struct packed {
        t_ctrl              ctrl;
        logic [NIB_W-1:0]   nib;
        logic               spr_hit;
        logic [COLOR_W-1:0] pix_color;
        logic [COLOR_W-1:0] spr_color;
    } t_dec_item;

    typedef struct packed {
        logic                empty;
        logic [QUEUE_AW:0]   used;
    } t_q_stat;

    function automatic logic in_range(input logic [CODE_W-1:0] idx);
        return 32'(idx) < 32'(PALETTE_DEPTH);
    endfunction

    function automatic logic [PAL_AW-1:0] pal_addr(input logic [CODE_W-1:0] idx);
        return PAL_AW'(idx);
    endfunction

endpackage

@@ hdl/hamd_ifs.sv @@
interface hamd_pix_if import hamd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [CODE_W-1:0]  pixel_code;
    logic [CODE_W-1:0]  sprite_code;
    logic [CODE_W-1:0]  palette_addr;
    logic [COLOR_W-1:0] palette_value;

    modport source (output valid, op, pixel_code, sprite_code, palette_addr, palette_value,
                    input ready);
    modport sink   (input valid, op, pixel_code, sprite_code, palette_addr, palette_value,
                    output ready);
endinterface

interface hamd_col_if import hamd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] host_color;

    modport source (output valid, host_color, input ready);
    modport sink   (input valid, host_color, output ready);
endinterface

interface hamd_cfg_if import hamd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/hamd_ram.sv @@
module hamd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

@@ hdl/hamd_front.sv @@
module hamd_front import hamd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hamd_pix_if.sink   i_pix,
    input  t_q_stat    i_qstat,
    output logic       o_push,
    output t_dec_item  o_item
);

    logic               w_acc;
    logic               w_we;
    logic               w_re;
    logic [QUEUE_AW+1:0] w_load;
    logic [COLOR_W-1:0] w_rd0;
    logic [COLOR_W-1:0] w_rd1;

    logic               r_f_vld;
    t_ctrl              r_ctrl;
    logic [NIB_W-1:0]   r_nib;
    logic               r_spr_hit;
    logic               r_pix_ok;
    logic               r_spr_ok;

    // room for the beat in flight plus a new one
    assign w_load      = (QUEUE_AW+2)'(i_qstat.used) + (QUEUE_AW+2)'(r_f_vld);
    assign i_pix.ready = w_load < (QUEUE_AW+2)'(QUEUE_DEPTH);

    assign w_acc = i_pix.valid && i_pix.ready;
    assign w_we  = w_acc && (i_pix.op == OP_PALETTE) && in_range(i_pix.palette_addr);
    assign w_re  = w_acc && (i_pix.op == OP_PIXEL);

    hamd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (pal_addr(i_pix.palette_addr)),
        .i_wdata  (i_pix.palette_value),
        .i_re     (w_re),
        .i_raddr0 (pal_addr(i_pix.pixel_code)),
        .i_raddr1 (pal_addr(i_pix.sprite_code)),
        .o_rdata0 (w_rd0),
        .o_rdata1 (w_rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_ctrl    <= t_ctrl'(i_pix.pixel_code[5:4]);
            r_nib     <= i_pix.pixel_code[3:0];
            r_spr_hit <= (i_pix.sprite_code != '0);
            r_pix_ok  <= in_range(i_pix.pixel_code);
            r_spr_ok  <= in_range(i_pix.sprite_code);
        end
    end

    assign o_push           = r_f_vld;
    assign o_item.ctrl      = r_ctrl;
    assign o_item.nib       = r_nib;
    assign o_item.spr_hit   = r_spr_hit;
    assign o_item.pix_color = r_pix_ok ? w_rd0 : '0;
    assign o_item.spr_color = r_spr_ok ? w_rd1 : '0;

endmodule

@@ hdl/hamd_queue.sv @@
module hamd_queue import hamd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_dec_item  i_item,
    input  logic       i_pop,
    output t_q_stat    o_stat,
    output t_dec_item  o_head
);

    t_dec_item           r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_used <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_used <= r_used + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_stat.used  = r_used;
    assign o_stat.empty = (r_used == '0);
    assign o_head       = r_mem[r_rp];

endmodule

@@ hdl/hamd_back.sv @@
module hamd_back import hamd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hamd_cfg_if.sink   i_cfg,
    hamd_col_if.source o_col,
    input  t_q_stat    i_qstat,
    input  t_dec_item  i_head,
    output logic       o_pop
);

    logic [SHIFT_W-1:0] r_shift_b, r_shift_r, r_shift_g;
    logic [COLOR_W-1:0] r_keep_b, r_keep_r, r_keep_g;
    logic [COLOR_W-1:0] r_held;
    logic               r_out_vld;
    logic [COLOR_W-1:0] r_out_col;

    logic [SHIFT_W-1:0] w_shift;
    logic [COLOR_W-1:0] w_keep;
    logic [COLOR_W-1:0] n_held;
    logic [COLOR_W-1:0] n_out_col;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_b <= RST_BLUE_SHIFT;
            r_keep_b  <= RST_BLUE_KEEP;
            r_shift_r <= RST_RED_SHIFT;
            r_keep_r  <= RST_RED_KEEP;
            r_shift_g <= RST_GREEN_SHIFT;
            r_keep_g  <= RST_GREEN_KEEP;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BLUE_SHIFT:  r_shift_b <= i_cfg.data[SHIFT_W-1:0];
                REG_BLUE_KEEP:   r_keep_b  <= i_cfg.data;
                REG_RED_SHIFT:   r_shift_r <= i_cfg.data[SHIFT_W-1:0];
                REG_RED_KEEP:    r_keep_r  <= i_cfg.data;
                REG_GREEN_SHIFT: r_shift_g <= i_cfg.data[SHIFT_W-1:0];
                REG_GREEN_KEEP:  r_keep_g  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_head.ctrl)
            CTRL_BLUE: begin
                w_shift = r_shift_b;
                w_keep  = r_keep_b;
            end
            CTRL_RED: begin
                w_shift = r_shift_r;
                w_keep  = r_keep_r;
            end
            CTRL_GREEN: begin
                w_shift = r_shift_g;
                w_keep  = r_keep_g;
            end
            default: begin
                w_shift = '0;
                w_keep  = '0;
            end
        endcase
    end

    assign o_pop = !i_qstat.empty && (!r_out_vld || o_col.ready);

    always_comb begin
        if (i_head.ctrl == CTRL_LOAD) begin
            n_held = i_head.pix_color;
        end else begin
            n_held = (r_held & w_keep) | (COLOR_W'(i_head.nib) << w_shift);
        end
        n_out_col = i_head.spr_hit ? i_head.spr_color : n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_held    <= n_held;
                r_out_vld <= 1'b1;
            end else if (o_col.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_col <= n_out_col;
        end
    end

    assign o_col.valid      = r_out_vld;
    assign o_col.host_color = r_out_col;

endmodule

@@ hdl/hold_and_modify_pixel_decoder.sv @@
// A pixel beat is read from the palette RAM, pushed into the queue and registered at o_col.
// One beat per cycle if the queue has room; a palette write uses one input slot, no output.
// A four-entry queue between the palette lookup and the color update absorbs output stalls.
// Reset (synchronous, active low) clears the held color, the queue and the output valid,
// and loads the default shifts and keep masks; palette contents stay undefined until written.
module hold_and_modify_pixel_decoder import hamd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hamd_pix_if.sink   i_pix,
    hamd_cfg_if.sink   i_cfg,
    hamd_col_if.source o_col
);

    t_q_stat   w_qstat;
    t_dec_item w_push_item;
    t_dec_item w_head;
    logic      w_push;
    logic      w_pop;

    hamd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    hamd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_stat  (w_qstat),
        .o_head  (w_head)
    );

    hamd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_col   (o_col),
        .i_qstat (w_qstat),
        .i_head  (w_head),
        .o_pop   (w_pop)
    );

endmodule

@@ hdl/hamd_checker.sv @@
`include "hold_and_modify_pixel_decoder_assert.svh"

module hamd_checker import hamd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_op,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [COLOR_W-1:0] i_out_color,
    input logic               i_cfg_ready
);

    `HAMD_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `HAMD_ASSERT_NXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_color))
    // a fresh output beat comes from an accepted pixel beat
    `HAMD_ASSERT_NOW(a_out_origin, $rose(i_out_valid),
        $past(i_in_valid && i_in_ready && (i_in_op == OP_PIXEL), 3))
    `HAMD_ASSERT_NOW(a_cfg_open, 1'b1, i_cfg_ready)

endmodule

bind hold_and_modify_pixel_decoder hamd_checker u_hamd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_op     (i_pix.op),
    .i_out_valid (o_col.valid),
    .i_out_ready (o_col.ready),
    .i_out_color (o_col.host_color),
    .i_cfg_ready (i_cfg.ready)
);

@@ sim/hold_and_modify_pixel_decoder_tb.sv @@
`timescale 1ns / 100ps

module hold_and_modify_pixel_decoder_tb;
    import hamd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int REPORT_LIMIT = 10;

    class ham_color_board;
        logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
        logic [COLOR_W-1:0] held;
        logic [SHIFT_W-1:0] shift_by [4];
        logic [COLOR_W-1:0] keep_by [4];
        logic [COLOR_W-1:0] pending_colors [$];
        int                 mismatches;

        function new();
            held                = '0;
            mismatches          = 0;
            shift_by[CTRL_BLUE]  = RST_BLUE_SHIFT;
            keep_by[CTRL_BLUE]   = RST_BLUE_KEEP;
            shift_by[CTRL_RED]   = RST_RED_SHIFT;
            keep_by[CTRL_RED]    = RST_RED_KEEP;
            shift_by[CTRL_GREEN] = RST_GREEN_SHIFT;
            keep_by[CTRL_GREEN]  = RST_GREEN_KEEP;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] wdata);
            case (idx)
                REG_BLUE_SHIFT:  shift_by[CTRL_BLUE]  = wdata[SHIFT_W-1:0];
                REG_BLUE_KEEP:   keep_by[CTRL_BLUE]   = wdata;
                REG_RED_SHIFT:   shift_by[CTRL_RED]   = wdata[SHIFT_W-1:0];
                REG_RED_KEEP:    keep_by[CTRL_RED]    = wdata;
                REG_GREEN_SHIFT: shift_by[CTRL_GREEN] = wdata[SHIFT_W-1:0];
                REG_GREEN_KEEP:  keep_by[CTRL_GREEN]  = wdata;
                default: ;
            endcase
        endfunction

        function logic [COLOR_W-1:0] lookup(logic [CODE_W-1:0] idx);
            if (int'(idx) >= PALETTE_DEPTH)
                return '0;
            return palette[idx];
        endfunction

        function void note_beat(logic op, logic [CODE_W-1:0] pix, logic [CODE_W-1:0] spr,
                                logic [CODE_W-1:0] addr, logic [COLOR_W-1:0] value);
            t_ctrl              ctrl;
            logic [COLOR_W-1:0] nib;
            if (op == OP_PALETTE) begin
                if (int'(addr) < PALETTE_DEPTH)
                    palette[addr] = value;
                return;
            end
            ctrl = t_ctrl'(pix[CODE_W-1:NIB_W]);
            if (ctrl == CTRL_LOAD) begin
                held = lookup(pix);
            end else begin
                nib  = COLOR_W'(pix[NIB_W-1:0]) << shift_by[ctrl];
                held = (held & keep_by[ctrl]) | nib;
            end
            pending_colors.push_back((spr != '0) ? lookup(spr) : held);
        endfunction

        function void check_color(logic [COLOR_W-1:0] got);
            logic [COLOR_W-1:0] want;
            if (pending_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("color beat with nothing pending: got %h", got);
                return;
            end
            want = pending_colors.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("host_color mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hamd_pix_if pix_bus ();
    hamd_cfg_if cfg_bus ();
    hamd_col_if col_bus ();

    hold_and_modify_pixel_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .i_cfg   (cfg_bus),
        .o_col   (col_bus)
    );

    ham_color_board board = new();
    bit             written [PALETTE_DEPTH];
    bit             idling_on = 1'b0;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (col_bus.valid && col_bus.ready)
                board.check_color(col_bus.host_color);
            if (pix_bus.valid && pix_bus.ready)
                board.note_beat(pix_bus.op, pix_bus.pixel_code, pix_bus.sprite_code,
                                pix_bus.palette_addr, pix_bus.palette_value);
        end
    end

    // output back-pressure
    initial begin
        col_bus.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                col_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                col_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(logic op, logic [CODE_W-1:0] pix, logic [CODE_W-1:0] spr,
                             logic [CODE_W-1:0] addr, logic [COLOR_W-1:0] value);
        pix_bus.valid         <= 1'b1;
        pix_bus.op            <= op;
        pix_bus.pixel_code    <= pix;
        pix_bus.sprite_code   <= spr;
        pix_bus.palette_addr  <= addr;
        pix_bus.palette_value <= value;
        do @(posedge i_clk); while (!pix_bus.ready);
        if (op == OP_PALETTE)
            written[addr] = 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic write_palette(logic [CODE_W-1:0] addr, logic [COLOR_W-1:0] value);
        send_beat(OP_PALETTE, CODE_W'($urandom), CODE_W'($urandom), addr, value);
    endtask

    // never read an entry that has not been written
    task automatic decode_pixel(logic [CODE_W-1:0] pix, logic [CODE_W-1:0] spr);
        if (t_ctrl'(pix[CODE_W-1:NIB_W]) == CTRL_LOAD && !written[pix])
            write_palette(pix, $urandom);
        if (spr != '0 && !written[spr])
            write_palette(spr, $urandom);
        send_beat(OP_PIXEL, pix, spr, CODE_W'($urandom), $urandom);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] wdata);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= wdata;
        do @(posedge i_clk); while (!cfg_bus.ready);
        board.set_reg(idx, wdata);
    endtask

    task automatic write_random_regs();
        write_reg(REG_BLUE_SHIFT, $urandom);
        write_reg(REG_BLUE_KEEP, pick_color());
        write_reg(REG_RED_SHIFT, $urandom);
        write_reg(REG_RED_KEEP, pick_color());
        write_reg(REG_GREEN_SHIFT, $urandom);
        write_reg(REG_GREEN_KEEP, pick_color());
        write_reg(REG_SPARE_6, $urandom);
        cfg_bus.valid <= 1'b0;
    endtask

    // hold input until all colors are back and the pipe is empty
    task automatic settle();
        pix_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_pixels(int count);
        logic [CODE_W-1:0] spr;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                write_palette(CODE_W'($urandom_range(0, PALETTE_DEPTH - 1)), pick_color());
            end else begin
                spr = ($urandom_range(0, 9) < 6) ? '0 : CODE_W'($urandom_range(1, 63));
                decode_pixel(CODE_W'($urandom), spr);
            end
        end
    endtask

    initial begin
        pix_bus.valid         <= 1'b0;
        pix_bus.op            <= OP_PIXEL;
        pix_bus.pixel_code    <= '0;
        pix_bus.sprite_code   <= '0;
        pix_bus.palette_addr  <= '0;
        pix_bus.palette_value <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_BLUE_SHIFT;
        cfg_bus.data          <= '0;
        i_rst_n               <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default shifts and masks
        write_palette(6'd0, 32'h0000_0000);
        write_palette(6'd15, 32'hFFFF_FFFF);
        write_palette(6'd63, 32'hA5A5_5A5A);
        write_palette(6'd1, 32'h1234_5678);
        write_palette(6'd32, 32'h0F0F_0F0F);
        decode_pixel(6'h0F, 6'd0);
        decode_pixel(6'h10, 6'd0);
        decode_pixel(6'h2F, 6'd0);
        decode_pixel(6'h30, 6'd0);
        decode_pixel(6'h3F, 6'd0);
        decode_pixel(6'h1F, 6'd0);
        decode_pixel(6'h00, 6'd0);
        decode_pixel(6'h20, 6'd0);
        decode_pixel(6'h15, 6'd63);
        decode_pixel(6'h3A, 6'd1);
        decode_pixel(6'h01, 6'd32);
        // palette write leaves the held color alone
        write_palette(6'd15, 32'h0000_0001);
        decode_pixel(6'h11, 6'd0);
        decode_pixel(6'h0F, 6'd0);
        settle();

        // extremes, nibble shifted past bit 31
        write_reg(REG_BLUE_SHIFT, '1);
        write_reg(REG_BLUE_KEEP, '0);
        write_reg(REG_RED_SHIFT, '0);
        write_reg(REG_RED_KEEP, '1);
        write_reg(REG_GREEN_SHIFT, 32'd28);
        write_reg(REG_GREEN_KEEP, 32'hF0F0_F0F0);
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, '1);
        cfg_bus.valid <= 1'b0;
        decode_pixel(6'h1F, 6'd0);
        decode_pixel(6'h2F, 6'd0);
        decode_pixel(6'h3F, 6'd0);
        decode_pixel(6'h10, 6'd0);
        idling_on = 1'b1;
        run_pixels(PHASE_ITEMS);
        settle();

        repeat (3) begin
            write_random_regs();
            run_pixels(PHASE_ITEMS);
            settle();
        end

        write_reg(REG_BLUE_SHIFT, 32'(RST_BLUE_SHIFT));
        write_reg(REG_BLUE_KEEP, RST_BLUE_KEEP);
        write_reg(REG_RED_SHIFT, 32'(RST_RED_SHIFT));
        write_reg(REG_RED_KEEP, RST_RED_KEEP);
        write_reg(REG_GREEN_SHIFT, 32'(RST_GREEN_SHIFT));
        write_reg(REG_GREEN_KEEP, RST_GREEN_KEEP);
        cfg_bus.valid <= 1'b0;
        idling_on = 1'b0;
        run_pixels(PHASE_ITEMS);
        settle();

        if (board.mismatches == 0 && board.pending_colors.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
